/* hw/rtl/pfdrc_pkg.sv */
// ----------------------------------------------------------------------------
// pfdrc_pkg
// Shared types, constants and helpers of the packet FIFO with duplicate filter.
// ----------------------------------------------------------------------------
package pfdrc_pkg;

   localparam int QUEUE_DEPTH = 64;
   localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_W       = 7;
   localparam int CNT_W       = 7;
   localparam int PKT_W       = 64;

   localparam logic [CSR_W-1:0] LIMIT_RESET = 7'd64;
   localparam logic [CNT_W-1:0] CNT_MAX     = 7'h7F;

   localparam logic [1:0] MODE_ADD   = 2'd0;
   localparam logic [1:0] MODE_FWD   = 2'd1;
   localparam logic [1:0] MODE_COUNT = 2'd2;

   typedef struct packed {
      logic [1:0]  mode;
      logic [15:0] source;
      logic [15:0] destination;
      logic [31:0] timestamp;
      logic [31:0] start_time;
      logic [31:0] end_time;
   } req_type;

   typedef struct packed {
      logic              accepted;
      logic              packet_valid;
      logic [15:0]       out_source;
      logic [15:0]       out_destination;
      logic [31:0]       out_timestamp;
      logic [CNT_W-1:0]  match_count;
   } rsp_type;

   typedef struct packed {
      logic [15:0] source;
      logic [15:0] destination;
      logic [31:0] timestamp;
   } packet_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } result_type;

   function automatic logic [OCC_W-1:0] eff_limit(input logic [CSR_W-1:0] value);
      logic [OCC_W-1:0] lim;
      if (value == '0) begin
         lim = OCC_W'(1);
      end else if (int'(value) > QUEUE_DEPTH) begin
         lim = OCC_W'(QUEUE_DEPTH);
      end else begin
         lim = OCC_W'(value);
      end
      return lim;
   endfunction

   function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx);
      logic [IDX_W-1:0] nxt;
      if (idx == IDX_W'(QUEUE_DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = idx + 1'b1;
      end
      return nxt;
   endfunction

endpackage

/* hw/rtl/pfdrc_ram.sv */
// ----------------------------------------------------------------------------
// pfdrc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pfdrc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/pfdrc_engine.sv */
// ----------------------------------------------------------------------------
// pfdrc_engine
// Queue sequencer: head and occupancy, store scans for add and count, pops.
// ----------------------------------------------------------------------------
module pfdrc_engine (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  pfdrc_pkg::req_type             req_data,
   input  logic [pfdrc_pkg::CSR_W-1:0]    queue_limit,
   output pfdrc_pkg::result_type          result,
   input  logic                           result_take
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SCAN = 4'b0010,
      ST_FWD  = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type                          state_ff, state_in;
   logic [pfdrc_pkg::IDX_W-1:0]        head_ff, head_in;
   logic [pfdrc_pkg::OCC_W-1:0]        occ_ff, occ_in;
   logic [pfdrc_pkg::OCC_W-1:0]        issue_ff, issue_in;
   logic [pfdrc_pkg::IDX_W-1:0]        slot_ff, slot_in;
   logic                               pend_ff, pend_in;
   logic                               dup_ff, dup_in;
   logic [pfdrc_pkg::CNT_W-1:0]        cnt_ff, cnt_in;
   pfdrc_pkg::req_type                 req_ff, req_in;
   pfdrc_pkg::rsp_type                 res_ff, res_in;

   logic                               accept;
   logic                               rd_en;
   logic [pfdrc_pkg::IDX_W-1:0]        rd_addr;
   logic [pfdrc_pkg::PKT_W-1:0]        rd_word;
   pfdrc_pkg::packet_type              rd_pkt;
   logic                               wr_en;
   logic [pfdrc_pkg::IDX_W-1:0]        wr_addr;
   pfdrc_pkg::packet_type              wr_pkt;
   logic [pfdrc_pkg::OCC_W:0]          tail_sum;
   logic [pfdrc_pkg::OCC_W-1:0]        lim;
   logic                               evict;
   logic                               hit_dup;
   logic                               hit_cnt;

   pfdrc_ram #(
      .WIDTH (pfdrc_pkg::PKT_W),
      .DEPTH (pfdrc_pkg::QUEUE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_pkt),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   assign rd_pkt    = pfdrc_pkg::packet_type'(rd_word);
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign lim       = pfdrc_pkg::eff_limit(queue_limit);
   assign evict     = (occ_ff >= lim);

   assign tail_sum = (pfdrc_pkg::OCC_W + 1)'(head_ff) + (pfdrc_pkg::OCC_W + 1)'(occ_ff);
   always_comb begin
      if (tail_sum >= (pfdrc_pkg::OCC_W + 1)'(pfdrc_pkg::QUEUE_DEPTH)) begin
         wr_addr = pfdrc_pkg::IDX_W'(tail_sum -
                   (pfdrc_pkg::OCC_W + 1)'(pfdrc_pkg::QUEUE_DEPTH));
      end else begin
         wr_addr = pfdrc_pkg::IDX_W'(tail_sum);
      end
   end

   assign wr_pkt.source      = req_ff.source;
   assign wr_pkt.destination = req_ff.destination;
   assign wr_pkt.timestamp   = req_ff.timestamp;

   assign hit_dup = (rd_pkt.source == req_ff.source) &&
                    (rd_pkt.destination == req_ff.destination) &&
                    (rd_pkt.timestamp == req_ff.timestamp);
   assign hit_cnt = (rd_pkt.destination == req_ff.destination) &&
                    (rd_pkt.timestamp >= req_ff.start_time) &&
                    (rd_pkt.timestamp <= req_ff.end_time);

   always_comb begin
      state_in = state_ff;
      head_in  = head_ff;
      occ_in   = occ_ff;
      issue_in = issue_ff;
      slot_in  = slot_ff;
      pend_in  = 1'b0;
      dup_in   = dup_ff;
      cnt_in   = cnt_ff;
      req_in   = req_ff;
      res_in   = res_ff;
      rd_en    = 1'b0;
      rd_addr  = slot_ff;
      wr_en    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in   = req_data;
               res_in   = '0;
               issue_in = '0;
               slot_in  = head_ff;
               dup_in   = 1'b0;
               cnt_in   = '0;
               unique case (req_data.mode)
                  pfdrc_pkg::MODE_ADD, pfdrc_pkg::MODE_COUNT: begin
                     state_in = ST_SCAN;
                  end
                  pfdrc_pkg::MODE_FWD: begin
                     if (occ_ff != '0) begin
                        rd_en    = 1'b1;
                        rd_addr  = head_ff;
                        state_in = ST_FWD;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (issue_ff < occ_ff) begin
               rd_en    = 1'b1;
               issue_in = issue_ff + 1'b1;
               slot_in  = pfdrc_pkg::next_slot(slot_ff);
               pend_in  = 1'b1;
            end
            if (pend_ff) begin
               if (hit_dup) begin
                  dup_in = 1'b1;
               end
               if (hit_cnt && (cnt_ff != pfdrc_pkg::CNT_MAX)) begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
            if ((issue_ff == occ_ff) && !pend_ff) begin
               state_in = ST_DONE;
               if (req_ff.mode == pfdrc_pkg::MODE_ADD) begin
                  if (!dup_ff) begin
                     wr_en           = 1'b1;
                     res_in.accepted = 1'b1;
                     if (evict) begin
                        head_in = pfdrc_pkg::next_slot(head_ff);
                     end else begin
                        occ_in = occ_ff + 1'b1;
                     end
                  end
               end else begin
                  res_in.match_count = cnt_ff;
               end
            end
         end
         ST_FWD: begin
            res_in.packet_valid    = 1'b1;
            res_in.out_source      = rd_pkt.source;
            res_in.out_destination = rd_pkt.destination;
            res_in.out_timestamp   = rd_pkt.timestamp;
            head_in                = pfdrc_pkg::next_slot(head_ff);
            occ_in                 = occ_ff - 1'b1;
            state_in               = ST_DONE;
         end
         ST_DONE: begin
            if (result_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         occ_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         occ_ff   <= occ_in;
         pend_ff  <= pend_in;
      end
      issue_ff <= issue_in;
      slot_ff  <= slot_in;
      dup_ff   <= dup_in;
      cnt_ff   <= cnt_in;
      req_ff   <= req_in;
      res_ff   <= res_in;
   end

   assign result.valid = (state_ff == ST_DONE);
   assign result.data  = res_ff;

endmodule

/* hw/rtl/packet_fifo_dedup_range_count.sv */
// ----------------------------------------------------------------------------
// packet_fifo_dedup_range_count
// Bounded packet FIFO with duplicate filter and range count, top level.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  carries one command item: add a packet, forward the oldest packet,
//          or count queued packets for a destination within a time window.
//   rsp_*  returns exactly one result item per command, in command order.
//   csr_*  writes queue_limit; csr_ready is always high. Write it only while
//          no command is outstanding.
// Flow:
//   add and count scan every queued packet through the store's single read
//   port, one per cycle. forward reads the oldest packet and pops it; an
//   unused mode or an empty forward goes straight to the result.
//   One command is in flight at a time; the next is taken once the result
//   has moved to the output register.
// Reset:
//   The queue is empty and queue_limit returns to 64. The store needs no
//   clearing pass.
// Stall:
//   A stalled result holds in the output register; one further command is
//   processed and its result waits in the engine until the register frees.
// ----------------------------------------------------------------------------
module packet_fifo_dedup_range_count (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  pfdrc_pkg::req_type             req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output pfdrc_pkg::rsp_type             rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [pfdrc_pkg::CSR_W-1:0]    csr_data
);

   logic [pfdrc_pkg::CSR_W-1:0]  limit_ff, limit_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   pfdrc_pkg::rsp_type           rsp_data_ff, rsp_data_in;
   pfdrc_pkg::result_type        result;
   logic                         out_free;

   pfdrc_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .queue_limit (limit_ff),
      .result      (result),
      .result_take (out_free)
   );

   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      limit_in     = limit_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (csr_valid && csr_ready) begin
         limit_in = csr_data;
      end
      if (out_free) begin
         rsp_valid_in = result.valid;
         if (result.valid) begin
            rsp_data_in = result.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= pfdrc_pkg::LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* tb/tb_packet_fifo_dedup_range_count.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_packet_fifo_dedup_range_count
// Self-checking bench for the bounded packet FIFO with duplicate filter.
// A scoreboard keeps its own copy of the queue and the limit register, works
// out the result of every accepted command, and compares each result field by
// field in order. A directed run covers empty forwards, field extremes,
// duplicates, reversed ranges and the clamped limits. Random phases then mix
// adds, forwards and counts over small value pools, with input gaps, output
// stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_packet_fifo_dedup_range_count;

   localparam logic [1:0] MODE_SPARE    = 2'd3;
   localparam int         SETTLE_CYCLES = 80;
   localparam int         HOLD_CYCLES   = 400;
   localparam int         IDLE_LIMIT    = 3000;

   class packet_queue_scoreboard;
      pfdrc_pkg::packet_type       store [pfdrc_pkg::QUEUE_DEPTH];
      int unsigned                 head;
      int unsigned                 occ;
      logic [pfdrc_pkg::CSR_W-1:0] limit;
      pfdrc_pkg::rsp_type          pending_results [$];
      int                          errors;

      function new();
         head   = 0;
         occ    = 0;
         limit  = pfdrc_pkg::LIMIT_RESET;
         errors = 0;
      endfunction

      task report(input string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         errors++;
      endtask

      task apply_command(input pfdrc_pkg::req_type c);
         pfdrc_pkg::rsp_type     want;
         pfdrc_pkg::packet_type  p;
         bit                     dup;
         int unsigned            cap;
         int unsigned            hits;
         pfdrc_pkg::packet_type  q;
         want = '0;
         p    = '{c.source, c.destination, c.timestamp};
         case (c.mode)
            pfdrc_pkg::MODE_ADD: begin
               dup = 1'b0;
               for (int unsigned i = 0; i < occ; i++) begin
                  if (store[(head + i) % pfdrc_pkg::QUEUE_DEPTH] == p) dup = 1'b1;
               end
               if (!dup) begin
                  cap = (limit == 0) ? 1 :
                        ((limit > pfdrc_pkg::QUEUE_DEPTH) ? pfdrc_pkg::QUEUE_DEPTH : limit);
                  // evict only the single oldest item
                  if (occ >= cap) begin
                     head = (head + 1) % pfdrc_pkg::QUEUE_DEPTH;
                     occ--;
                  end
                  store[(head + occ) % pfdrc_pkg::QUEUE_DEPTH] = p;
                  occ++;
                  want.accepted = 1'b1;
               end
            end
            pfdrc_pkg::MODE_FWD: begin
               if (occ != 0) begin
                  q                    = store[head];
                  want.packet_valid    = 1'b1;
                  want.out_source      = q.source;
                  want.out_destination = q.destination;
                  want.out_timestamp   = q.timestamp;
                  head = (head + 1) % pfdrc_pkg::QUEUE_DEPTH;
                  occ--;
               end
            end
            pfdrc_pkg::MODE_COUNT: begin
               hits = 0;
               for (int unsigned i = 0; i < occ; i++) begin
                  q = store[(head + i) % pfdrc_pkg::QUEUE_DEPTH];
                  if (q.destination == c.destination && q.timestamp >= c.start_time &&
                      q.timestamp <= c.end_time && hits < pfdrc_pkg::CNT_MAX) hits++;
               end
               want.match_count = (pfdrc_pkg::CNT_W)'(hits);
            end
            default: ;
         endcase
         pending_results.insert(pending_results.size(), want);
      endtask

      task check_field(input string name, input logic [31:0] got, input logic [31:0] want);
         if (got !== want) report($sformatf("%s is %0h, expected %0h", name, got, want));
      endtask

      task check_result(input pfdrc_pkg::rsp_type got);
         pfdrc_pkg::rsp_type want;
         if (pending_results.size() == 0) begin
            report("result with no command outstanding");
            return;
         end
         want = pending_results.pop_front();
         check_field("accepted", 32'(got.accepted), 32'(want.accepted));
         check_field("packet_valid", 32'(got.packet_valid), 32'(want.packet_valid));
         check_field("out_source", 32'(got.out_source), 32'(want.out_source));
         check_field("out_destination", 32'(got.out_destination), 32'(want.out_destination));
         check_field("out_timestamp", got.out_timestamp, want.out_timestamp);
         check_field("match_count", 32'(got.match_count), 32'(want.match_count));
      endtask
   endclass

   logic                        clock     = 1'b0;
   logic                        reset     = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   pfdrc_pkg::req_type          req_data  = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   pfdrc_pkg::rsp_type          rsp_data;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [pfdrc_pkg::CSR_W-1:0] csr_data  = '0;

   packet_queue_scoreboard sb;
   int sender_idle_pct = 0;
   int rsp_stall_pct   = 0;
   int hold_seq        = 0;
   int hold_seen       = 0;
   int hold_left       = 0;
   int idle_cycles     = 0;

   packet_fifo_dedup_range_count dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #1 clock = ~clock;

   // receiver: random stalls, or a long hold-off when requested
   always @(negedge clock) begin
      if (hold_seq != hold_seen) begin
         hold_seen = hold_seq;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         rsp_stall = 1'b1;
         hold_left--;
      end else begin
         rsp_stall = ($urandom_range(0, 99) < rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_data);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   function automatic pfdrc_pkg::req_type cmd(input logic [1:0] mode, input logic [15:0] src,
                                              input logic [15:0] dst, input logic [31:0] ts,
                                              input logic [31:0] t0, input logic [31:0] t1);
      pfdrc_pkg::req_type c;
      c = '{mode, src, dst, ts, t0, t1};
      return c;
   endfunction

   function automatic pfdrc_pkg::req_type random_command(input int add_pct);
      pfdrc_pkg::req_type     c;
      pfdrc_pkg::packet_type  p;
      int unsigned            roll;
      c.source      = ($urandom_range(0, 99) < 70) ? 16'($urandom_range(0, 3)) : 16'($urandom);
      c.destination = ($urandom_range(0, 99) < 70) ? 16'($urandom_range(0, 3)) : 16'($urandom);
      c.timestamp   = ($urandom_range(0, 99) < 60) ? 32'($urandom_range(0, 15)) : $urandom;
      c.start_time  = $urandom;
      c.end_time    = $urandom;
      roll = $urandom_range(0, 99);
      if (roll < add_pct) begin
         c.mode = pfdrc_pkg::MODE_ADD;
      end else begin
         roll   = $urandom_range(0, 99);
         c.mode = (roll < 40) ? pfdrc_pkg::MODE_FWD :
                  ((roll < 92) ? pfdrc_pkg::MODE_COUNT : MODE_SPARE);
      end
      roll = $urandom_range(0, 99);
      if (c.mode == pfdrc_pkg::MODE_ADD && sb.occ != 0 && roll < 25) begin
         // replay a queued item, often the oldest
         p = sb.store[(sb.head + ((roll < 8) ? 0 : $urandom_range(0, sb.occ - 1))) %
                      pfdrc_pkg::QUEUE_DEPTH];
         c.source      = p.source;
         c.destination = p.destination;
         c.timestamp   = p.timestamp;
      end
      if (c.mode == pfdrc_pkg::MODE_COUNT) begin
         if (sb.occ != 0 && roll < 60) begin
            p = sb.store[(sb.head + $urandom_range(0, sb.occ - 1)) % pfdrc_pkg::QUEUE_DEPTH];
            c.destination = p.destination;
         end
         roll = $urandom_range(0, 99);
         if (roll < 60) begin
            c.start_time = $urandom_range(0, 15);
            c.end_time   = c.start_time + $urandom_range(0, 15);
         end else if (roll < 70) begin
            c.start_time = $urandom_range(1, 15);
            c.end_time   = c.start_time - $urandom_range(1, c.start_time);
         end else if (roll < 80) begin
            c.start_time = '0;
            c.end_time   = '1;
         end
      end
      return c;
   endfunction

   task automatic send_item(input pfdrc_pkg::req_type item);
      @(negedge clock);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.apply_command(item);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [pfdrc_pkg::CSR_W-1:0] value);
      wait_idle();
      @(negedge clock);
      csr_valid = 1'b1;
      csr_data  = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.limit = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic run_phase(input logic [pfdrc_pkg::CSR_W-1:0] value, input int send_idle,
                            input int stall, input int add_pct, input int items,
                            input bit pressure);
      write_limit(value);
      sender_idle_pct = send_idle;
      rsp_stall_pct   = stall;
      if (pressure) hold_seq++;
      repeat (items) send_item(random_command(add_pct));
   endtask

   initial begin
      sb = new();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_item(cmd(pfdrc_pkg::MODE_FWD, '1, '1, '1, '1, '1));
      send_item(cmd(pfdrc_pkg::MODE_COUNT, '0, '0, '0, '0, '1));
      send_item(cmd(MODE_SPARE, '1, '1, '1, '1, '0));
      send_item(cmd(pfdrc_pkg::MODE_ADD, '0, '0, '0, '1, '1));
      send_item(cmd(pfdrc_pkg::MODE_ADD, '1, '1, '1, '0, '0));
      send_item(cmd(pfdrc_pkg::MODE_ADD, '0, '0, '0, '0, '0));
      send_item(cmd(pfdrc_pkg::MODE_ADD, '0, '0, 32'd1, '0, '0));
      send_item(cmd(pfdrc_pkg::MODE_COUNT, '0, '1, '0, '0, '1));
      send_item(cmd(pfdrc_pkg::MODE_COUNT, '0, '0, '0, 32'd1, '0));
      send_item(cmd(pfdrc_pkg::MODE_COUNT, '0, '0, '0, '0, '0));
      send_item(cmd(pfdrc_pkg::MODE_FWD, '0, '0, '0, '0, '0));

      // queue holds two items at a limit of two: the duplicate of the oldest must not evict
      write_limit(7'd2);
      send_item(cmd(pfdrc_pkg::MODE_ADD, '1, '1, '1, '0, '0));
      send_item(cmd(pfdrc_pkg::MODE_ADD, 16'd1, 16'd2, 32'd3, '0, '0));
      send_item(cmd(pfdrc_pkg::MODE_COUNT, '0, 16'd2, '0, 32'd3, 32'd3));

      // limit of zero acts as one, below the current occupancy
      write_limit(7'd0);
      send_item(cmd(pfdrc_pkg::MODE_ADD, 16'd1, 16'd2, 32'd3, '0, '0));
      send_item(cmd(pfdrc_pkg::MODE_ADD, 16'd7, 16'd7, 32'd7, '0, '0));
      send_item(cmd(pfdrc_pkg::MODE_FWD, '0, '0, '0, '0, '0));
      send_item(cmd(pfdrc_pkg::MODE_FWD, '0, '0, '0, '0, '0));
      send_item(cmd(pfdrc_pkg::MODE_FWD, '0, '0, '0, '0, '0));
      write_limit(7'd127);

      run_phase(7'd64, 0, 0, 70, 120, 1'b0);
      run_phase(7'd3, 75, 0, 45, 90, 1'b0);
      run_phase(7'd50, 0, 75, 55, 80, 1'b0);
      run_phase(7'd1, 30, 30, 50, 80, 1'b0);
      run_phase(7'd64, 0, 0, 60, 60, 1'b1);

      wait_idle();
      if (sb.errors == 0 && sb.pending_results.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
